@@ hdl/slot_pool_allocator_assert.svh @@
// Assertion macros used by the slot pool allocator RTL.
`ifndef SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define SLOT_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPA_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/spa_pkg.sv @@
// Shared types and constants of the slot pool allocator.
package spa_pkg;

  localparam int CAPACITY = 256;
  localparam int ID_W     = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LINK_W   = $clog2(CAPACITY + 1);
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CMD_W    = 2;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

endpackage

@@ hdl/spa_ram.sv @@
// Simple dual-port RAM with one write port and a registered read port.
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/slot_pool_allocator.sv @@
// Slot pool allocator: LIFO free list of slots, each stamped with a unique id.
//
// A request is taken when start is high and busy is low. in_command selects
// allocate, release, lookup or clear; in_slot qualifies a release or a
// lookup, and in_handle_id a release. Every request gives exactly one
// result: out_valid is high for one cycle with out_status, out_slot_out,
// out_id_out, out_live and out_live_count. The receiver cannot stall, so
// results are never held. The link and id memories are read at the accepting
// edge; the execute state then checks, writes back and registers the result.
// busy is high in the execute state, so no new request is taken until it
// ends. out_valid is registered from busy and rises with the registered
// result at the edge that ends the execute state. Clear drops a per-slot
// valid vector at once, and a slot that is not valid reads as free with its
// link pointing to the next slot. Reset does the same, so the pool is usable
// on the first cycle after reset with no sweep of the memories.
module slot_pool_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [spa_pkg::CMD_W-1:0]     in_command,
  input  logic [spa_pkg::SLOT_W-1:0]    in_slot,
  input  logic [spa_pkg::ID_W-1:0]      in_handle_id,
  output logic                          out_valid,
  output logic [spa_pkg::STATUS_W-1:0]  out_status,
  output logic [spa_pkg::SLOT_W-1:0]    out_slot_out,
  output logic [spa_pkg::ID_W-1:0]      out_id_out,
  output logic                          out_live,
  output logic [spa_pkg::LINK_W-1:0]    out_live_count
);
  import spa_pkg::*;

  `include "slot_pool_allocator_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [ID_W-1:0]       hid_r;
  logic [IDX_W-1:0]      addr_r;
  logic [LINK_W-1:0]     head_r, head_nxt;
  logic [LINK_W-1:0]     alive_r, alive_nxt;
  logic [ID_W-1:0]       idctr_r, idctr_nxt;
  logic [CAPACITY-1:0]   touched_r, touched_nxt;

  logic                  accept;
  logic [IDX_W-1:0]      raddr;
  logic [LINK_W-1:0]     link_rd, link_eff;
  logic [ID_W:0]         slot_rd;
  logic                  slot_live, in_range, id_match, free_ok, full;
  logic                  link_we, slot_we;
  logic [ID_W:0]         slot_wd;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [ID_W-1:0]       out_id_r, out_id_nxt;
  logic                  out_live_r, out_live_nxt;

  assign busy   = (state_r == S_EXEC);
  assign accept = start && !busy;
  assign raddr  = (cmd_t'(in_command) == CMD_ALLOC) ? head_r[IDX_W-1:0] : in_slot[IDX_W-1:0];

  spa_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (addr_r),
    .wdata (head_r),
    .raddr (raddr),
    .rdata (link_rd)
  );

  // Each entry holds the live flag above the stored id.
  spa_ram #(.WIDTH(ID_W + 1), .DEPTH(CAPACITY)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (addr_r),
    .wdata (slot_wd),
    .raddr (raddr),
    .rdata (slot_rd)
  );

  // An entry not written since the last clear or reset reads as its reset contents.
  assign link_eff  = touched_r[addr_r] ? link_rd : (LINK_W'(addr_r) + LINK_W'(1));
  assign slot_live = touched_r[addr_r] && slot_rd[ID_W];
  assign in_range  = ({1'b0, slot_r} < LINK_W'(CAPACITY));
  assign id_match  = (slot_rd[ID_W-1:0] == hid_r);
  assign full      = (head_r == NULL_LINK);
  assign free_ok   = in_range && slot_live && id_match;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    alive_nxt      = alive_r;
    idctr_nxt      = idctr_r;
    touched_nxt    = touched_r;
    link_we        = 1'b0;
    slot_we        = 1'b0;
    slot_wd        = {1'b0, hid_r};
    out_status_nxt = ST_OK;
    out_slot_nxt   = slot_r;
    out_id_nxt     = '0;
    out_live_nxt   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (cmd_r)
          CMD_ALLOC: begin
            out_slot_nxt = '0;
            if (full) begin
              out_status_nxt = ST_FULL;
            end else begin
              head_nxt             = link_eff;
              slot_we              = 1'b1;
              slot_wd              = {1'b1, idctr_r};
              touched_nxt[addr_r]  = 1'b1;
              idctr_nxt            = idctr_r + ID_W'(1);
              alive_nxt            = alive_r + LINK_W'(1);
              out_slot_nxt         = SLOT_W'(addr_r);
              out_id_nxt           = idctr_r;
              out_live_nxt         = 1'b1;
            end
          end
          CMD_FREE: begin
            if (free_ok) begin
              link_we    = 1'b1;
              slot_we    = 1'b1;
              head_nxt   = LINK_W'(addr_r);
              if (alive_r != '0) begin
                alive_nxt = alive_r - LINK_W'(1);
              end
              out_id_nxt = hid_r;
            end else begin
              out_status_nxt = ST_INVALID;
            end
          end
          CMD_LOOKUP: begin
            if (!in_range) begin
              out_status_nxt = ST_INVALID;
            end else if (slot_live) begin
              out_id_nxt   = slot_rd[ID_W-1:0];
              out_live_nxt = 1'b1;
            end
          end
          CMD_CLEAR: begin
            touched_nxt  = '0;
            head_nxt     = '0;
            alive_nxt    = '0;
            out_slot_nxt = '0;
          end
          default: begin
            out_status_nxt = ST_INVALID;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      alive_r     <= '0;
      idctr_r     <= '0;
      touched_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      alive_r     <= alive_nxt;
      idctr_r     <= idctr_nxt;
      touched_r   <= touched_nxt;
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd_t'(in_command);
      slot_r <= in_slot;
      hid_r  <= in_handle_id;
      addr_r <= raddr;
    end
    if (busy) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_id_r     <= out_id_nxt;
      out_live_r   <= out_live_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_out   = out_slot_r;
  assign out_id_out     = out_id_r;
  assign out_live       = out_live_r;
  assign out_live_count = alive_r;

  `SPA_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, busy && !out_valid,
                   "accepted request did not enter execute")
  `SPA_ASSERT_NEXT(a_exec_result, clk, rst_n, busy, out_valid && !busy,
                   "execute cycle gave no single result")
  `SPA_ASSERT_NOW(a_full_count, clk, rst_n, full, alive_r == LINK_W'(CAPACITY),
                  "empty free list while slots remain free")
  `SPA_ASSERT_NOW(a_full_status, clk, rst_n, out_valid && out_status == ST_FULL,
                  out_live_count == LINK_W'(CAPACITY) && !out_live,
                  "full status with free slots left")

endmodule

@@ sim/tb_slot_pool_allocator.sv @@
// Self-checking testbench for the slot pool allocator: directed table, then random traffic.
module tb_slot_pool_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import spa_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int SEGMENT_LEN  = 300;
  localparam int MAX_GAP      = 12;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     id;
    logic                live;
    logic [LINK_W-1:0]   count;
  } pool_reply_t;

  typedef struct {
    cmd_t            cmd;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   handle;
    bit              typed;
    pool_reply_t     reply;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [CMD_W-1:0]    in_command = '0;
  logic [SLOT_W-1:0]   in_slot = '0;
  logic [ID_W-1:0]     in_handle_id = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot_out;
  logic [ID_W-1:0]     out_id_out;
  logic                out_live;
  logic [LINK_W-1:0]   out_live_count;

  // Shadow copy of the pool.
  logic [LINK_W-1:0] free_chain [CAPACITY];
  logic [ID_W-1:0]   slot_stamp [CAPACITY];
  bit                slot_held  [CAPACITY];
  logic [LINK_W-1:0] chain_head;
  logic [ID_W-1:0]   stamp_next;
  logic [LINK_W-1:0] held_total;

  pool_reply_t awaited_replies [$];
  int          mismatch_count = 0;
  int          sender_idle_pct = 0;

  localparam pool_reply_t UNTYPED = '0;

  stim_row_t directed_rows [21] = '{
    '{CMD_LOOKUP, 8'd0,   32'h0000_0000, 1'b1, '{ST_OK,      8'd0,   32'd0, 1'b0, 9'd0}},
    '{CMD_LOOKUP, 8'd255, 32'hFFFF_FFFF, 1'b1, '{ST_OK,      8'd255, 32'd0, 1'b0, 9'd0}},
    '{CMD_FREE,   8'd0,   32'h0000_0000, 1'b1, '{ST_INVALID, 8'd0,   32'd0, 1'b0, 9'd0}},
    '{CMD_ALLOC,  8'd255, 32'hFFFF_FFFF, 1'b1, '{ST_OK,      8'd0,   32'd0, 1'b1, 9'd1}},
    '{CMD_ALLOC,  8'd0,   32'h0000_0000, 1'b1, '{ST_OK,      8'd1,   32'd1, 1'b1, 9'd2}},
    '{CMD_LOOKUP, 8'd1,   32'h0000_0000, 1'b0, UNTYPED},
    '{CMD_FREE,   8'd1,   32'h0000_0000, 1'b1, '{ST_INVALID, 8'd1,   32'd0, 1'b0, 9'd2}},
    '{CMD_FREE,   8'd1,   32'h0000_0001, 1'b0, UNTYPED},
    '{CMD_ALLOC,  8'd0,   32'h0000_0000, 1'b0, UNTYPED},
    '{CMD_FREE,   8'd255, 32'hFFFF_FFFF, 1'b1, '{ST_INVALID, 8'd255, 32'd0, 1'b0, 9'd2}},
    '{CMD_FREE,   8'd0,   32'h8000_0000, 1'b1, '{ST_INVALID, 8'd0,   32'd0, 1'b0, 9'd2}},
    '{CMD_CLEAR,  8'd0,   32'h0000_0000, 1'b1, '{ST_OK,      8'd0,   32'd0, 1'b0, 9'd0}},
    '{CMD_CLEAR,  8'd170, 32'h5555_5555, 1'b1, '{ST_OK,      8'd0,   32'd0, 1'b0, 9'd0}},
    '{CMD_LOOKUP, 8'd1,   32'h0000_0000, 1'b0, UNTYPED},
    '{CMD_FREE,   8'd0,   32'h0000_0000, 1'b1, '{ST_INVALID, 8'd0,   32'd0, 1'b0, 9'd0}},
    '{CMD_ALLOC,  8'd0,   32'h0000_0000, 1'b0, UNTYPED},
    '{CMD_LOOKUP, 8'd0,   32'h0000_0000, 1'b0, UNTYPED},
    '{CMD_FREE,   8'd0,   32'h0000_0003, 1'b0, UNTYPED},
    '{CMD_ALLOC,  8'd0,   32'h0000_0000, 1'b0, UNTYPED},
    '{CMD_FREE,   8'd0,   32'hAAAA_AAAA, 1'b0, UNTYPED},
    '{CMD_CLEAR,  8'd0,   32'h0000_0000, 1'b0, UNTYPED}
  };

  slot_pool_allocator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_slot        (in_slot),
    .in_handle_id   (in_handle_id),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot_out   (out_slot_out),
    .out_id_out     (out_id_out),
    .out_live       (out_live),
    .out_live_count (out_live_count)
  );

  always #10 clk = ~clk;

  function automatic void rebuild_pool();
    for (int k = 0; k < CAPACITY; k++) begin
      free_chain[k] = LINK_W'(k + 1);
      slot_held[k]  = 1'b0;
    end
    chain_head = '0;
    held_total = '0;
  endfunction

  function automatic pool_reply_t predict_pool_reply(cmd_t cmd, logic [SLOT_W-1:0] slot,
                                                     logic [ID_W-1:0] handle);
    pool_reply_t r;
    logic [IDX_W-1:0] taken;
    r = '{status: ST_OK, slot: slot, id: '0, live: 1'b0, count: '0};
    case (cmd)
      CMD_ALLOC: begin
        r.slot = '0;
        if (chain_head == NULL_LINK) begin
          r.status = ST_FULL;
        end else begin
          taken = chain_head[IDX_W-1:0];
          chain_head = free_chain[taken];
          slot_held[taken] = 1'b1;
          slot_stamp[taken] = stamp_next;
          stamp_next = stamp_next + 1'b1;
          held_total = held_total + 1'b1;
          r.slot = taken;
          r.id = slot_stamp[taken];
          r.live = 1'b1;
        end
      end
      CMD_FREE: begin
        // Every 8-bit slot index is in range, so only liveness and the id decide.
        if (!slot_held[slot] || slot_stamp[slot] != handle) begin
          r.status = ST_INVALID;
        end else begin
          slot_held[slot] = 1'b0;
          free_chain[slot] = chain_head;
          chain_head = LINK_W'(slot);
          held_total = held_total - 1'b1;
          r.id = handle;
        end
      end
      CMD_LOOKUP: begin
        if (slot_held[slot]) begin
          r.id = slot_stamp[slot];
          r.live = 1'b1;
        end
      end
      default: begin
        rebuild_pool();
        r.slot = '0;
      end
    endcase
    r.count = held_total;
    return r;
  endfunction

  function automatic bit find_held_slot(output logic [IDX_W-1:0] found);
    int base;
    int idx;
    found = '0;
    base = $urandom_range(CAPACITY - 1);
    for (int k = 0; k < CAPACITY; k++) begin
      idx = (base + k) % CAPACITY;
      if (slot_held[idx]) begin
        found = IDX_W'(idx);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Traffic mixes by index: fill the pool, churn it, or drain it.
  task automatic pick_request(input int mix, output cmd_t cmd, output logic [SLOT_W-1:0] slot,
                              output logic [ID_W-1:0] handle);
    int alloc_w [3] = '{95, 35, 8};
    int good_w  [3] = '{1, 30, 70};
    int bad_w   [3] = '{1, 8, 5};
    int clear_w [3] = '{0, 1, 0};
    int roll;
    logic [IDX_W-1:0] held;
    roll = $urandom_range(99);
    slot = SLOT_W'($urandom);
    handle = $urandom;
    if (roll < alloc_w[mix]) begin
      cmd = CMD_ALLOC;
    end else if (roll < alloc_w[mix] + good_w[mix]) begin
      cmd = CMD_FREE;
      if (find_held_slot(held)) begin
        slot = held;
        handle = slot_stamp[held];
      end
    end else if (roll < alloc_w[mix] + good_w[mix] + bad_w[mix]) begin
      cmd = CMD_FREE;
      // When a slot is held, half of the broken releases name a live slot with one id bit flipped.
      if ($urandom_range(1) == 1 && find_held_slot(held)) begin
        slot = held;
        handle = slot_stamp[held] ^ (32'd1 << $urandom_range(ID_W - 1));
      end
    end else if (roll < alloc_w[mix] + good_w[mix] + bad_w[mix] + clear_w[mix]) begin
      cmd = CMD_CLEAR;
    end else begin
      cmd = CMD_LOOKUP;
      if ($urandom_range(1) == 1 && find_held_slot(held)) slot = held;
    end
  endtask

  task automatic issue_request(input cmd_t cmd, input logic [SLOT_W-1:0] slot,
                               input logic [ID_W-1:0] handle, input bit typed,
                               input pool_reply_t typed_reply);
    pool_reply_t predicted;
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_slot <= slot;
    in_handle_id <= handle;
    do @(posedge clk); while (busy);
    predicted = predict_pool_reply(cmd, slot, handle);
    awaited_replies.push_back(typed ? typed_reply : predicted);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  always @(posedge clk) begin
    pool_reply_t exp_r;
    if (rst_n && out_valid) begin
      if (awaited_replies.size() == 0) begin
        $error("result with no request outstanding: status %0d slot %0d id %h",
               out_status, out_slot_out, out_id_out);
        mismatch_count++;
      end else begin
        exp_r = awaited_replies.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
          mismatch_count++;
        end
        if (out_slot_out !== exp_r.slot) begin
          $error("slot_out: expected %0d, got %0d", exp_r.slot, out_slot_out);
          mismatch_count++;
        end
        if (out_id_out !== exp_r.id) begin
          $error("id_out: expected %h, got %h", exp_r.id, out_id_out);
          mismatch_count++;
        end
        if (out_live !== exp_r.live) begin
          $error("live: expected %0d, got %0d", exp_r.live, out_live);
          mismatch_count++;
        end
        if (out_live_count !== exp_r.count) begin
          $error("live_count: expected %0d, got %0d", exp_r.count, out_live_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cmd_t             cmd;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   handle;
    rebuild_pool();
    stamp_next = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 34;
    foreach (directed_rows[i])
      issue_request(directed_rows[i].cmd, directed_rows[i].slot, directed_rows[i].handle,
                    directed_rows[i].typed, directed_rows[i].reply);
    hold_until_drained();

    // The clear at the end of the table leaves the pool empty, so the first
    // fill segment runs it into the full state.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3) begin
        hold_until_drained();
        sender_idle_pct = (i == RANDOM_ITEMS / 3) ? 70 : 0;
      end
      pick_request((i / SEGMENT_LEN) % 3, cmd, slot, handle);
      issue_request(cmd, slot, handle, 1'b0, UNTYPED);
    end

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("slot_pool_allocator verification clean");
    end else begin
      $display("slot_pool_allocator verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("slot_pool_allocator verification failed");
    $finish;
  end

endmodule

@@ slot_pool_allocator.f @@
+incdir+hdl
hdl/spa_pkg.sv
hdl/spa_ram.sv
hdl/slot_pool_allocator.sv
sim/tb_slot_pool_allocator.sv
